>>> rtl/dcbd_pkg.sv
package dcbd_pkg;

    localparam int BYTE_W   = 8;
    localparam int OP_W     = 5;
    localparam int COORD_W  = 16;
    localparam int PAL_W    = 32;
    localparam int IDX_W    = 9;
    localparam int STEP_W   = 4;

    // step counter stops here once the header has been read
    localparam logic [STEP_W-1:0] STEP_CAP = 4'd15;

    // command codes
    localparam logic [OP_W-1:0] OP_NOP        = 5'd0;
    localparam logic [OP_W-1:0] OP_BUTTON     = 5'd1;
    localparam logic [OP_W-1:0] OP_SET_COLOR  = 5'd2;
    localparam logic [OP_W-1:0] OP_END_SCENE  = 5'd3;
    localparam logic [OP_W-1:0] OP_SET_BACK   = 5'd4;
    localparam logic [OP_W-1:0] OP_RECT       = 5'd5;
    localparam logic [OP_W-1:0] OP_TEXT       = 5'd6;
    localparam logic [OP_W-1:0] OP_PALETTE    = 5'd7;
    localparam logic [OP_W-1:0] OP_FILL_RECT  = 5'd8;
    localparam logic [OP_W-1:0] OP_VLINE      = 5'd9;
    localparam logic [OP_W-1:0] OP_HLINE      = 5'd10;
    localparam logic [OP_W-1:0] OP_SET_FONT   = 5'd11;
    localparam logic [OP_W-1:0] OP_POINT      = 5'd12;
    localparam logic [OP_W-1:0] OP_LINE       = 5'd13;
    localparam logic [OP_W-1:0] OP_TESTER     = 5'd14;
    localparam logic [OP_W-1:0] OP_BIG_TEXT   = 5'd15;
    localparam logic [OP_W-1:0] OP_SCREEN_REQ = 5'd16;

    // first byte value that is not a command
    localparam logic [BYTE_W-1:0] OP_LIMIT = 8'd17;

    typedef struct packed {
        logic [OP_W-1:0]    op_code;
        logic [COORD_W-1:0] pos_x;
        logic [BYTE_W-1:0]  pos_y;
        logic [COORD_W-1:0] extent_a;
        logic [BYTE_W-1:0]  extent_b;
        logic [PAL_W-1:0]   palette_value;
        logic [BYTE_W-1:0]  aux_one;
        logic [BYTE_W-1:0]  aux_two;
        logic [BYTE_W-1:0]  payload_byte;
        logic [IDX_W-1:0]   payload_index;
        logic               last_flag;
    } rec_t;

    // handshake between parser and output stage
    typedef struct packed {
        logic take;
        logic emit;
        logic free;
    } flow_t;

endpackage

>>> rtl/dcbd_in_stage.sv
module dcbd_in_stage
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          data_valid,
    output logic                          data_ready,
    input  logic [dcbd_pkg::BYTE_W-1:0]   data_byte,
    input  logic                          out_free,
    output logic                          take,
    output logic [dcbd_pkg::BYTE_W-1:0]   byte_q
);

    logic                        valid_reg;
    logic                        valid_next;
    logic [dcbd_pkg::BYTE_W-1:0] byte_reg;
    logic                        load;

    // byte leaves when the result side has room
    assign take       = valid_reg && out_free;
    assign data_ready = !valid_reg || take;
    assign load       = data_valid && data_ready;
    assign byte_q     = byte_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= data_byte;
        end
    end

endmodule

>>> rtl/dcbd_parser.sv
module dcbd_parser
#(
    parameter int POINT_COUNT = 256
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        take,
    input  logic [dcbd_pkg::BYTE_W-1:0] byte_q,
    output logic                        emit,
    output logic                        idle,
    output dcbd_pkg::rec_t              rec
);

    localparam int CNT_RAW = $clog2(2 * POINT_COUNT + 1);
    localparam int CNT_W   = (CNT_RAW > dcbd_pkg::IDX_W) ? CNT_RAW : dcbd_pkg::IDX_W;
    localparam logic [CNT_W:0] PT_TOTAL = (CNT_W + 1)'(2 * POINT_COUNT);

    logic [dcbd_pkg::STEP_W-1:0]  step_reg, step_next, step_adv;
    logic [dcbd_pkg::OP_W-1:0]    op_reg, op_next;
    logic [dcbd_pkg::COORD_W-1:0] x_reg, x_next;
    logic [dcbd_pkg::BYTE_W-1:0]  y_reg, y_next;
    logic [dcbd_pkg::COORD_W-1:0] ext_a_reg, ext_a_next;
    logic [dcbd_pkg::PAL_W-1:0]   pal_reg, pal_next;
    logic [dcbd_pkg::BYTE_W-1:0]  aux_reg, aux_next;
    logic [dcbd_pkg::BYTE_W-1:0]  aux2_reg, aux2_next;
    logic [dcbd_pkg::BYTE_W-1:0]  len_reg, len_next;
    logic [CNT_W-1:0]             cnt_reg, cnt_next;
    logic [CNT_W:0]               cnt_inc;
    logic [CNT_W:0]               text_total;
    logic [dcbd_pkg::BYTE_W-1:0]  ext_b;
    logic [dcbd_pkg::BYTE_W-1:0]  pb;
    logic [dcbd_pkg::IDX_W-1:0]   pi;
    logic                         last;
    logic                         text_last;
    logic                         pt_last;

    assign step_adv   = (step_reg == dcbd_pkg::STEP_CAP) ? step_reg : step_reg + 1'b1;
    assign cnt_inc    = {1'b0, cnt_reg} + 1'b1;
    assign text_total = (CNT_W + 1)'(len_reg);
    assign text_last  = cnt_inc >= text_total;
    assign pt_last    = cnt_inc >= PT_TOTAL;
    assign idle       = (step_reg == '0);

    always_comb
    begin
        step_next  = step_reg;
        op_next    = op_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        ext_a_next = ext_a_reg;
        pal_next   = pal_reg;
        aux_next   = aux_reg;
        aux2_next  = aux2_reg;
        len_next   = len_reg;
        cnt_next   = cnt_reg;
        emit       = 1'b0;
        ext_b      = '0;
        pb         = '0;
        pi         = '0;
        last       = 1'b0;

        if (step_reg == '0)
        begin
            // opcode byte; anything out of range is dropped
            if (byte_q < dcbd_pkg::OP_LIMIT)
            begin
                op_next    = byte_q[dcbd_pkg::OP_W-1:0];
                x_next     = '0;
                y_next     = '0;
                ext_a_next = '0;
                pal_next   = '0;
                aux_next   = '0;
                aux2_next  = '0;
                len_next   = '0;
                cnt_next   = '0;
                case (byte_q[dcbd_pkg::OP_W-1:0])
                    dcbd_pkg::OP_NOP:
                    begin
                    end
                    dcbd_pkg::OP_END_SCENE, dcbd_pkg::OP_SCREEN_REQ:
                    begin
                        emit = 1'b1;
                        last = 1'b1;
                    end
                    default:
                    begin
                        step_next = 4'd1;
                    end
                endcase
            end
        end
        else
        begin
            step_next = step_adv;
            case (op_reg)
                dcbd_pkg::OP_BUTTON:
                begin
                    if (step_reg >= 4'd2)
                    begin
                        step_next = '0;
                    end
                end
                dcbd_pkg::OP_SET_COLOR, dcbd_pkg::OP_SET_BACK, dcbd_pkg::OP_SET_FONT:
                begin
                    aux_next  = byte_q;
                    emit      = 1'b1;
                    last      = 1'b1;
                    step_next = '0;
                end
                dcbd_pkg::OP_RECT, dcbd_pkg::OP_FILL_RECT, dcbd_pkg::OP_LINE:
                begin
                    case (step_reg)
                        4'd1: x_next = {x_reg[15:8], byte_q};
                        4'd2: x_next = {byte_q, x_reg[7:0]};
                        4'd3: y_next = byte_q;
                        4'd4: ext_a_next = {ext_a_reg[15:8], byte_q};
                        4'd5: ext_a_next = {byte_q, ext_a_reg[7:0]};
                        default:
                        begin
                            ext_b     = byte_q;
                            emit      = 1'b1;
                            last      = 1'b1;
                            step_next = '0;
                        end
                    endcase
                end
                dcbd_pkg::OP_VLINE:
                begin
                    case (step_reg)
                        4'd1: x_next = {x_reg[15:8], byte_q};
                        4'd2: x_next = {byte_q, x_reg[7:0]};
                        4'd3: y_next = byte_q;
                        default:
                        begin
                            ext_b     = byte_q;
                            emit      = 1'b1;
                            last      = 1'b1;
                            step_next = '0;
                        end
                    endcase
                end
                dcbd_pkg::OP_HLINE:
                begin
                    case (step_reg)
                        4'd1: y_next = byte_q;
                        4'd2: x_next = {x_reg[15:8], byte_q};
                        4'd3: x_next = {byte_q, x_reg[7:0]};
                        4'd4: ext_a_next = {ext_a_reg[15:8], byte_q};
                        default:
                        begin
                            ext_a_next = {byte_q, ext_a_reg[7:0]};
                            emit       = 1'b1;
                            last       = 1'b1;
                            step_next  = '0;
                        end
                    endcase
                end
                dcbd_pkg::OP_POINT:
                begin
                    case (step_reg)
                        4'd1: x_next = {x_reg[15:8], byte_q};
                        4'd2: x_next = {byte_q, x_reg[7:0]};
                        default:
                        begin
                            y_next    = byte_q;
                            emit      = 1'b1;
                            last      = 1'b1;
                            step_next = '0;
                        end
                    endcase
                end
                dcbd_pkg::OP_PALETTE:
                begin
                    case (step_reg)
                        4'd1: aux_next = byte_q;
                        4'd2: pal_next = {pal_reg[31:8], byte_q};
                        4'd3: pal_next = {pal_reg[31:16], byte_q, pal_reg[7:0]};
                        4'd4: pal_next = {pal_reg[31:24], byte_q, pal_reg[15:0]};
                        default:
                        begin
                            pal_next  = {byte_q, pal_reg[23:0]};
                            emit      = 1'b1;
                            last      = 1'b1;
                            step_next = '0;
                        end
                    endcase
                end
                dcbd_pkg::OP_TEXT, dcbd_pkg::OP_BIG_TEXT:
                begin
                    // big text carries a size byte before the length
                    if (step_reg == 4'd1)
                    begin
                        x_next = {x_reg[15:8], byte_q};
                    end
                    else if (step_reg == 4'd2)
                    begin
                        x_next = {byte_q, x_reg[7:0]};
                    end
                    else if (step_reg == 4'd3)
                    begin
                        y_next = byte_q;
                    end
                    else if (op_reg == dcbd_pkg::OP_BIG_TEXT && step_reg == 4'd4)
                    begin
                        aux_next = byte_q;
                    end
                    else if ((op_reg == dcbd_pkg::OP_TEXT && step_reg == 4'd4)
                          || (op_reg == dcbd_pkg::OP_BIG_TEXT && step_reg == 4'd5))
                    begin
                        len_next = byte_q;
                        cnt_next = '0;
                        // empty string finishes right here
                        if (byte_q == '0)
                        begin
                            emit      = 1'b1;
                            last      = 1'b1;
                            step_next = '0;
                        end
                    end
                    else
                    begin
                        cnt_next = cnt_inc[CNT_W-1:0];
                        pb       = byte_q;
                        pi       = cnt_reg[dcbd_pkg::IDX_W-1:0];
                        emit     = 1'b1;
                        last     = text_last;
                        if (text_last)
                        begin
                            step_next = '0;
                        end
                    end
                end
                dcbd_pkg::OP_TESTER:
                begin
                    if (step_reg == 4'd1)
                    begin
                        aux_next = byte_q;
                    end
                    else if (step_reg == 4'd2)
                    begin
                        aux2_next = byte_q;
                        cnt_next  = '0;
                    end
                    else
                    begin
                        cnt_next = cnt_inc[CNT_W-1:0];
                        pb       = byte_q;
                        pi       = cnt_reg[dcbd_pkg::IDX_W-1:0];
                        emit     = 1'b1;
                        last     = pt_last;
                        if (pt_last)
                        begin
                            step_next = '0;
                        end
                    end
                end
                default:
                begin
                    step_next = '0;
                end
            endcase
        end
    end

    always_comb
    begin
        rec.op_code       = op_next;
        rec.pos_x         = x_next;
        rec.pos_y         = y_next;
        rec.extent_a      = ext_a_next;
        rec.extent_b      = ext_b;
        rec.palette_value = pal_next;
        rec.aux_one       = aux_next;
        rec.aux_two       = aux2_next;
        rec.payload_byte  = pb;
        rec.payload_index = pi;
        rec.last_flag     = last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= '0;
            op_reg    <= '0;
            x_reg     <= '0;
            y_reg     <= '0;
            ext_a_reg <= '0;
            pal_reg   <= '0;
            aux_reg   <= '0;
            aux2_reg  <= '0;
            len_reg   <= '0;
            cnt_reg   <= '0;
        end
        else if (take)
        begin
            step_reg  <= step_next;
            op_reg    <= op_next;
            x_reg     <= x_next;
            y_reg     <= y_next;
            ext_a_reg <= ext_a_next;
            pal_reg   <= pal_next;
            aux_reg   <= aux_next;
            aux2_reg  <= aux2_next;
            len_reg   <= len_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

>>> rtl/dcbd_out_stage.sv
module dcbd_out_stage
(
    input  logic           clk,
    input  logic           rst_n,
    input  dcbd_pkg::flow_t flow_in,
    input  dcbd_pkg::rec_t rec_in,
    input  logic           result_ready,
    output logic           result_valid,
    output logic           out_free,
    output dcbd_pkg::rec_t rec_q
);

    logic           valid_reg;
    logic           valid_next;
    dcbd_pkg::rec_t rec_reg;
    logic           load;

    assign out_free     = !valid_reg || result_ready;
    assign load         = flow_in.take && flow_in.emit;
    assign result_valid = valid_reg;
    assign rec_q        = rec_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rec_reg <= rec_in;
        end
    end

endmodule

>>> rtl/display_command_byte_decoder_core.sv
// channel   | valid / ready                 | payload
// ----------+-------------------------------+---------------------------------------------
// input     | data_valid / data_ready       | data_byte
// result    | result_valid / result_ready   | op_code .. last_flag (one decoded record)
//
// a byte beat is held in the byte register while the command parser works on it, and
// its record loads into the result register when that byte is taken, so each record
// beat passes through the byte register and then the result register
// sustained rate is one byte per cycle if unstalled; parser state update is the only loop
// reset clears the parser to wait for an opcode and empties both registers
// a stalled result holds the byte register; data_ready drops only when both are full
// and result_ready is low
module display_command_byte_decoder_core
#(
    parameter int POINT_COUNT = 256
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           data_valid,
    output logic                           data_ready,
    input  logic [dcbd_pkg::BYTE_W-1:0]    data_byte,
    output logic                           result_valid,
    input  logic                           result_ready,
    output logic [dcbd_pkg::OP_W-1:0]      op_code,
    output logic [dcbd_pkg::COORD_W-1:0]   pos_x,
    output logic [dcbd_pkg::BYTE_W-1:0]    pos_y,
    output logic [dcbd_pkg::COORD_W-1:0]   extent_a,
    output logic [dcbd_pkg::BYTE_W-1:0]    extent_b,
    output logic [dcbd_pkg::PAL_W-1:0]     palette_value,
    output logic [dcbd_pkg::BYTE_W-1:0]    aux_one,
    output logic [dcbd_pkg::BYTE_W-1:0]    aux_two,
    output logic [dcbd_pkg::BYTE_W-1:0]    payload_byte,
    output logic [dcbd_pkg::IDX_W-1:0]     payload_index,
    output logic                           last_flag
);

    // byte register to parser
    logic                        take;
    logic [dcbd_pkg::BYTE_W-1:0] byte_q;
    // parser to result register
    logic                        emit;
    logic                        idle;
    logic                        out_free;
    dcbd_pkg::rec_t              rec_d;
    dcbd_pkg::rec_t              rec_q;
    dcbd_pkg::flow_t             flow;

    assign flow.take = take;
    assign flow.emit = emit;
    assign flow.free = out_free;

    // input beat lands here first
    dcbd_in_stage u_in
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .data_valid (data_valid),
        .data_ready (data_ready),
        .data_byte  (data_byte),
        .out_free   (flow.free),
        .take       (take),
        .byte_q     (byte_q)
    );

    // command state, field gathering and record build
    dcbd_parser #(
        .POINT_COUNT (POINT_COUNT)
    ) u_parser
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .take   (take),
        .byte_q (byte_q),
        .emit   (emit),
        .idle   (idle),
        .rec    (rec_d)
    );

    // result register; loads only on a byte that finishes a record
    dcbd_out_stage u_out
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .flow_in      (flow),
        .rec_in       (rec_d),
        .result_ready (result_ready),
        .result_valid (result_valid),
        .out_free     (out_free),
        .rec_q        (rec_q)
    );

    assign op_code       = rec_q.op_code;
    assign pos_x         = rec_q.pos_x;
    assign pos_y         = rec_q.pos_y;
    assign extent_a      = rec_q.extent_a;
    assign extent_b      = rec_q.extent_b;
    assign palette_value = rec_q.palette_value;
    assign aux_one       = rec_q.aux_one;
    assign aux_two       = rec_q.aux_two;
    assign payload_byte  = rec_q.payload_byte;
    assign payload_index = rec_q.payload_index;
    assign last_flag     = rec_q.last_flag;

    // no-op and button press never produce a record
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (op_code != dcbd_pkg::OP_NOP && op_code != dcbd_pkg::OP_BUTTON))
        else $error("record emitted for a silent command");

    // only text and tester commands may emit a record that is not last
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && op_code != dcbd_pkg::OP_TEXT && op_code != dcbd_pkg::OP_BIG_TEXT
            && op_code != dcbd_pkg::OP_TESTER) |-> (last_flag && payload_index == '0))
        else $error("single-record command without last flag");

    // a record that closes a command puts the parser back to awaiting an opcode
    assert property (@(posedge clk) disable iff (!rst_n)
        (take && emit && rec_d.last_flag) |=> idle)
        else $error("parser not idle after last record");

endmodule
